>>> src/sdf_pkg.sv
`default_nettype none

package sdf_pkg;

  // Fixed field width of the value on both channels
  localparam int VALUE_W = 32;

  // Defaults for the top-level parameters
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int VALUE_BITS_DEF  = 32;

  // Entries in the queue between front and back
  localparam int Q_DEPTH = 2;

  // One queued input item
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } item_t;

  // Back-end sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

`default_nettype wire

>>> src/sdf_in_if.sv
`default_nettype none

interface sdf_in_if;
  import sdf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);

endinterface

`default_nettype wire

>>> src/sdf_out_if.sv
`default_nettype none

interface sdf_out_if;
  import sdf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value_out;
  logic                      keep;
  logic                      overflow;
  logic                      last_out;

  modport source (output valid, output value_out, output keep, output overflow,
                  output last_out, input ready);
  modport sink   (input valid, input value_out, input keep, input overflow,
                  input last_out, output ready);

endinterface

`default_nettype wire

>>> src/sdf_ram.sv
`default_nettype none

module sdf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> src/sdf_front.sv
`default_nettype none

module sdf_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  sdf_in_if.sink             in_ch,
  output logic               q_valid,
  input  wire logic          q_ready,
  output sdf_pkg::item_t     q_item
);
  import sdf_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  item_t            slot_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             push, pop;

  // handshake on both sides of the queue
  assign in_ch.ready = (fill_r != CNT_W'(Q_DEPTH));
  assign q_valid     = (fill_r != '0);
  assign q_item      = slot_r[rd_ptr_r];
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_valid && q_ready;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= '{value: in_ch.value, last: in_ch.last_item};
    end
  end

endmodule

`default_nettype wire

>>> src/sdf_back.sv
`default_nettype none

module sdf_back #(
  parameter int TABLE_DEPTH = sdf_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_BITS  = sdf_pkg::VALUE_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  output logic                  q_ready,
  input  wire sdf_pkg::item_t   q_item,
  sdf_out_if.source             out_ch
);
  import sdf_pkg::*;

  // compared bits, never more than the value field carries
  localparam int CMP_BITS = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int IDX_W    = $clog2(TABLE_DEPTH);
  localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [IDX_W-1:0]          rd_addr_r, rd_addr_nxt;
  item_t                     cur_r, cur_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic                      out_keep_r, out_keep_nxt;
  logic                      out_ovf_r, out_ovf_nxt;
  logic                      out_last_r, out_last_nxt;

  logic                      ram_we;
  logic [IDX_W-1:0]          ram_waddr;
  logic [CMP_BITS-1:0]       ram_wdata;
  logic [IDX_W-1:0]          ram_raddr;
  logic [CMP_BITS-1:0]       ram_rdata;

  logic                      slot_free;
  logic                      hit;
  logic                      at_end;
  logic                      full;
  logic                      fin;
  logic                      fin_keep;
  item_t                     fin_item;

  // table of distinct values in the current set
  sdf_ram #(
    .WIDTH (CMP_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // scan status
  assign slot_free = !out_valid_r || out_ch.ready;
  assign hit       = (ram_rdata == cur_r.value[CMP_BITS-1:0]);
  assign at_end    = ((CNT_W'(rd_addr_r) + CNT_W'(1)) == count_r);
  assign full      = (count_r == CNT_W'(TABLE_DEPTH));

  // sequencer: one table entry compared per cycle, holding on the final compare while the output is blocked
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rd_addr_nxt   = rd_addr_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_keep_nxt  = out_keep_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;
    q_ready       = 1'b0;
    ram_we        = 1'b0;
    ram_raddr     = rd_addr_r;
    fin           = 1'b0;
    fin_keep      = 1'b0;
    fin_item      = cur_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (count_r == '0) begin
            // empty table: first occurrence right away
            if (slot_free) begin
              q_ready  = 1'b1;
              fin      = 1'b1;
              fin_keep = 1'b1;
              fin_item = q_item;
            end
          end else begin
            q_ready     = 1'b1;
            cur_nxt     = q_item;
            ram_raddr   = '0;
            rd_addr_nxt = '0;
            state_nxt   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit || at_end) begin
          // hold the read address while the output is blocked
          if (slot_free) begin
            fin       = 1'b1;
            fin_keep  = !hit;
            state_nxt = ST_IDLE;
          end
        end else begin
          ram_raddr   = rd_addr_r + IDX_W'(1);
          rd_addr_nxt = rd_addr_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // result and table update
    if (fin) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = fin_item.value;
      out_keep_nxt  = fin_keep;
      out_ovf_nxt   = fin_keep && full;
      out_last_nxt  = fin_item.last;
      if (fin_keep && !full) begin
        ram_we    = 1'b1;
        count_nxt = count_r + CNT_W'(1);
      end
      if (fin_item.last) begin
        count_nxt = '0;
      end
    end
  end

  assign ram_waddr = count_r[IDX_W-1:0];
  assign ram_wdata = fin_item.value[CMP_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_addr_r   <= rd_addr_nxt;
    cur_r       <= cur_nxt;
    out_value_r <= out_value_nxt;
    out_keep_r  <= out_keep_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.value_out = out_value_r;
  assign out_ch.keep      = out_keep_r;
  assign out_ch.overflow  = out_ovf_r;
  assign out_ch.last_out  = out_last_r;

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("table count beyond depth");

  a_scan_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (CNT_W'(rd_addr_r) < count_r))
    else $error("scan reads past the filled entries");

  a_ovf_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ovf_r) |-> out_keep_r)
    else $error("overflow flagged on a dropped value");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_ready) |-> (state_r == ST_IDLE))
    else $error("queue popped during a scan");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fin && fin_item.last) |=> (count_r == '0))
    else $error("table not emptied after last item");

endmodule

`default_nettype wire

>>> src/stream_duplicate_filter.sv
`default_nettype none
// Channel   Dir  Payload                                   Transfer
// in_ch     in   value[31:0] s, last_item                  valid && ready
// out_ch    out  value_out[31:0] s, keep, overflow, last   valid && ready
//
// Scan: an item skips the scan when the table is empty; otherwise the scan
//   reads one table entry per cycle through the single read port of the
//   table RAM, ends early on a match and waits at its end on a held result.
// Reset: clears the entry count, the queue and the output register; the
//   table contents are never cleared, only entries below the count are read.
// Stalls: a two-entry queue takes input while a scan runs; a held result
//   in the output register pauses the scan on its final compare.
module stream_duplicate_filter #(
  parameter int TABLE_DEPTH = sdf_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_BITS  = sdf_pkg::VALUE_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sdf_in_if.sink     in_ch,
  sdf_out_if.source  out_ch
);
  import sdf_pkg::*;

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  // front: accept and queue items
  sdf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  // back: table scan, update and result
  sdf_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

>>> sim/stream_duplicate_filter_tb.sv
`timescale 1ns / 100ps

module stream_duplicate_filter_tb;
  import sdf_pkg::*;

  localparam int TBL_DEPTH   = TABLE_DEPTH_DEF;
  localparam int N_ITEMS     = 1450;
  localparam int N_FULL_SETS = 3;
  // Worst case: every item scans the full table while the receiver stalls
  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_WAIT  = TBL_DEPTH + 64;

  // Expected outcome of one value
  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               keep;
    logic               overflow;
    logic               last;
  } verdict_t;

  logic clk;
  logic rst_n;

  sdf_in_if  in_ch ();
  sdf_out_if out_ch ();

  stream_duplicate_filter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Items waiting to be sent and verdicts waiting to be seen
  item_t    send_q[$];
  verdict_t verdict_q[$];

  // Shadow of the table of distinct values in the current set
  logic [VALUE_W-1:0] seen_tbl[TBL_DEPTH];
  int                 seen_n;

  int error_cnt;
  int cycle_cnt;
  int sent_cnt;
  int set_cnt;
  int kept_cnt;
  int dropped_cnt;
  int overflow_cnt;

  // Sender pacing
  int burst_left;
  int gap_left;

  // Receiver stall pattern
  int stall_mode;
  int stall_win;
  int stall_phase;

  always #1 clk = ~clk;

  // Classify one value against the shadow table and update it
  function automatic verdict_t classify_value(logic [VALUE_W-1:0] v, logic last);
    verdict_t r;
    logic     hit;
    hit = 1'b0;
    for (int k = 0; k < seen_n; k++)
      if (seen_tbl[k] == v) hit = 1'b1;
    r.value    = v;
    r.last     = last;
    r.keep     = !hit;
    r.overflow = 1'b0;
    if (!hit) begin
      if (seen_n < TBL_DEPTH) begin
        seen_tbl[seen_n] = v;
        seen_n++;
      end else begin
        r.overflow = 1'b1;
      end
    end
    if (last) seen_n = 0;
    return r;
  endfunction

  task automatic flag_error(string msg);
    error_cnt++;
    if (error_cnt <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic add_item(logic [VALUE_W-1:0] v, logic last);
    item_t it;
    it.value = v;
    it.last  = last;
    send_q.insert(send_q.size(), it);
    if (last) set_cnt++;
  endtask

  // Short set: values drawn from a small pool so repeats are common
  task automatic add_short_set();
    logic [VALUE_W-1:0] pool[8];
    int                 len;
    int                 pick;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
    for (int k = 0; k < 8; k++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)      pool[k] = 32'h8000_0000;
      else if (pick == 1) pool[k] = 32'h7FFF_FFFF;
      else if (pick == 2) pool[k] = '1;
      else if (pick == 3) pool[k] = '0;
      else                pool[k] = $urandom;
    end
    for (int k = 0; k < len; k++)
      add_item(($urandom_range(0, 1) == 0) ? pool[$urandom_range(0, 7)] : $urandom,
               k == len - 1);
  endtask

  // Set that fills the table, then mixes overflowing values and repeats
  task automatic add_full_set();
    logic [VALUE_W-1:0] base;
    int                 extra;
    int                 pick;
    base  = $urandom;
    extra = $urandom_range(8, 24);
    for (int k = 0; k < TBL_DEPTH; k++)
      add_item(base + k, extra == 0 && k == TBL_DEPTH - 1);
    for (int k = 0; k < extra; k++) begin
      pick = $urandom_range(0, 2);
      if (pick == 0)      add_item(base + TBL_DEPTH + $urandom_range(0, 3), k == extra - 1);
      else if (pick == 1) add_item(base + $urandom_range(0, TBL_DEPTH - 1), k == extra - 1);
      else                add_item(base - 1 - $urandom_range(0, 1000), k == extra - 1);
    end
  endtask

  // Driver: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    item_t nx;
    logic  nv;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left  = $urandom_range(1, 40);
      gap_left    = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        verdict_q.insert(verdict_q.size(), classify_value(in_ch.value, in_ch.last_item));
        sent_cnt++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        nv = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (send_q.size() > 0) begin
          nx = send_q.pop_front();
          nv = 1'b1;
          in_ch.value     <= nx.value;
          in_ch.last_item <= nx.last;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end
        in_ch.valid <= nv;
      end
    end
  end

  // Monitor: check each result transfer, then set the next ready
  always @(posedge clk) begin
    verdict_t exp;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_win    = 0;
      stall_phase  = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (out_ch.keep === 1'b1) kept_cnt++;
        else dropped_cnt++;
        if (out_ch.overflow === 1'b1) overflow_cnt++;
        if (verdict_q.size() == 0) begin
          flag_error($sformatf("result with none expected: value %h", out_ch.value_out));
        end else begin
          exp = verdict_q.pop_front();
          if (out_ch.value_out !== exp.value || out_ch.keep !== exp.keep ||
              out_ch.overflow !== exp.overflow || out_ch.last_out !== exp.last)
            flag_error($sformatf(
              "exp value %h keep %b ovf %b last %b, got value %h keep %b ovf %b last %b",
              exp.value, exp.keep, exp.overflow, exp.last, out_ch.value_out,
              out_ch.keep, out_ch.overflow, out_ch.last_out));
        end
      end
      // switch stall pattern every so often
      if (stall_win == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_win  = $urandom_range(20, 200);
      end else begin
        stall_win--;
      end
      stall_phase = (stall_phase + 1) % 4;
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= (stall_phase == 0);
      endcase
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("stream_duplicate_filter_tb: errors");
      $finish;
    end
  end

  initial begin
    int full_done;
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.value     = '0;
    in_ch.last_item = 1'b0;
    out_ch.ready    = 1'b0;
    seen_n          = 0;
    error_cnt       = 0;
    cycle_cnt       = 0;
    sent_cnt        = 0;
    set_cnt         = 0;
    kept_cnt        = 0;
    dropped_cnt     = 0;
    overflow_cnt    = 0;
    full_done       = 0;

    // Directed: extremes, repeats, single-item sets, last item as repeat
    add_item(32'h8000_0000, 1'b0);
    add_item(32'h7FFF_FFFF, 1'b0);
    add_item(32'h0000_0000, 1'b0);
    add_item(32'hFFFF_FFFF, 1'b0);
    add_item(32'h8000_0000, 1'b0);
    add_item(32'hFFFF_FFFF, 1'b0);
    add_item(32'h5555_5555, 1'b0);
    add_item(32'hAAAA_AAAA, 1'b0);
    add_item(32'h7FFF_FFFF, 1'b1);
    // table cleared: the same values are first occurrences again
    add_item(32'h0000_0000, 1'b1);
    add_item(32'h8000_0000, 1'b1);
    add_item(32'h0000_0001, 1'b0);
    add_item(32'h0000_0001, 1'b0);
    add_item(32'h0000_0001, 1'b0);
    add_item(32'h0000_0002, 1'b1);
    add_item(32'hFFFF_FFFE, 1'b0);
    add_item(32'h7FFF_FFFE, 1'b0);
    add_item(32'hFFFF_FFFE, 1'b1);

    // Random sets, with a few that fill the table
    while (send_q.size() < N_ITEMS) begin
      if (full_done < N_FULL_SETS && send_q.size() >= 100 + full_done * 420) begin
        add_full_set();
        full_done++;
      end else begin
        add_short_set();
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all items to go in and all results to come out
    while (send_q.size() > 0 || in_ch.valid) @(posedge clk);
    while (verdict_q.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (verdict_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", verdict_q.size()));

    $display("sent %0d values in %0d sets; %0d kept, %0d dropped, %0d overflowed",
             sent_cnt, set_cnt, kept_cnt, dropped_cnt, overflow_cnt);
    $display("%0d errors over %0d cycles", error_cnt, cycle_cnt);
    if (error_cnt == 0) begin
      $display("stream_duplicate_filter_tb: clean");
    end else begin
      $display("stream_duplicate_filter_tb: errors");
    end
    $finish;
  end

endmodule
